/* design/rtcl_pkg.sv */
// Package for the rune type and case lookup block.
// Holds the item kinds, the range entry layout, the sequencer states and defaults.
// Used by rtcl_range_search.sv and rune_type_and_case_lookup.sv.
package rtcl_pkg;

   localparam int DIRECT_SIZE_DEF = 256;
   localparam int MAX_RANGES_DEF  = 64;
   localparam int TYPE_WORDS_DEF  = 4096;

   localparam int CODE_W  = 32;
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 12;

   // Input item kinds.
   localparam logic [1:0] KIND_QUERY  = 2'd0;
   localparam logic [1:0] KIND_DIRECT = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;
   localparam logic [1:0] KIND_WORD   = 2'd3;

   // Table selects.
   localparam logic [1:0] SEL_TYPE  = 2'd0;
   localparam logic [1:0] SEL_LOWER = 2'd1;
   localparam logic [1:0] SEL_UPPER = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_TYPE_COUNT  = 2'd0;
   localparam logic [1:0] REG_LOWER_COUNT = 2'd1;
   localparam logic [1:0] REG_UPPER_COUNT = 2'd2;

   typedef struct packed {
      logic [31:0]        low;
      logic [31:0]        high;
      logic [31:0]        value;
      logic               uses_types;
      logic [INDEX_W-1:0] base;
   } range_entry_type;

   typedef struct packed {
      logic done;
      logic hit;
   } search_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIRECT,
      ST_SEARCH,
      ST_WORD,
      ST_RESULT
   } state_type;

endpackage

/* design/rtcl_range_search.sv */
// One sorted range table in a synchronous memory, with its binary search.
// Depends on rtcl_pkg for the entry layout and the status struct.
module rtcl_range_search #(
   parameter int MAX_RANGES = rtcl_pkg::MAX_RANGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [rtcl_pkg::INDEX_W-1:0]         wr_slot,
   input  rtcl_pkg::range_entry_type            wr_entry,
   input  logic                                 start,
   input  logic [rtcl_pkg::COUNT_W-1:0]         count,
   input  logic [31:0]                          code,
   output rtcl_pkg::search_status_type          status,
   output rtcl_pkg::range_entry_type            entry
);

   localparam int IDXW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int LIMW = $clog2(MAX_RANGES + 1);

   rtcl_pkg::range_entry_type range_mem [MAX_RANGES];
   rtcl_pkg::range_entry_type rdata_ff;
   rtcl_pkg::range_entry_type entry_ff, entry_in;

   logic [LIMW-1:0] first_ff, first_in;
   logic [LIMW-1:0] lim_ff, lim_in;
   logic            busy_ff, busy_in;
   logic            phase_ff, phase_in;
   logic            hit_ff, hit_in;
   logic [LIMW-1:0] mid;
   logic [LIMW-1:0] lim_start;
   logic            rd_en;

   // The middle slot of the window still open.
   assign mid = first_ff + (lim_ff >> 1);
   assign lim_start = (32'(count) > 32'(MAX_RANGES)) ? LIMW'(MAX_RANGES) : LIMW'(count);
   assign rd_en = busy_ff && !phase_ff && (lim_ff != '0);

   // Range memory: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[IDXW'(wr_slot)] <= wr_entry;
      end
      if (rd_en) begin
         rdata_ff <= range_mem[IDXW'(mid)];
      end
   end

   // Search step: issue a read, then compare and narrow the window.
   always_comb begin
      first_in = first_ff;
      lim_in   = lim_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      hit_in   = hit_ff;
      entry_in = entry_ff;
      if (start) begin
         first_in = '0;
         lim_in   = lim_start;
         busy_in  = 1'b1;
         phase_in = 1'b0;
         hit_in   = 1'b0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            if (lim_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               phase_in = 1'b1;
            end
         end else begin
            phase_in = 1'b0;
            if (rdata_ff.low <= code && code <= rdata_ff.high) begin
               hit_in   = 1'b1;
               entry_in = rdata_ff;
               busy_in  = 1'b0;
            end else if (code > rdata_ff.high) begin
               first_in = mid + LIMW'(1);
               lim_in   = (lim_ff - LIMW'(1)) >> 1;
            end else begin
               lim_in = lim_ff >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         hit_ff   <= 1'b0;
         first_ff <= '0;
         lim_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         hit_ff   <= hit_in;
         first_ff <= first_in;
         lim_ff   <= lim_in;
      end
      entry_ff <= entry_in;
   end

   assign status.done = !busy_ff;
   assign status.hit  = hit_ff;
   assign entry       = entry_ff;

   // A read is only issued while the window is open inside the table.
   a_mid_in_table: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> 32'(mid) < 32'(MAX_RANGES))
      else $error("search slot beyond the table");

   // A compare phase always follows an issued read.
   a_phase_after_read: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && phase_ff) |-> $past(rd_en))
      else $error("compare without a read");

   // A hit ends the search.
   a_hit_ends: assert property (@(posedge clock) disable iff (reset)
      ($rose(hit_ff) && !$past(start)) |-> !busy_ff)
      else $error("search still busy after a hit");

endmodule

/* design/rune_type_and_case_lookup.sv */
// Top level of the rune type and case lookup block.
// Depends on rtcl_pkg and instantiates rtcl_range_search for three range tables.
//
// Usage: the req_ channel carries one item per transfer. Write items load the
// direct tables, the range tables or the type store and give no result. A query
// gives one result on the rsp_ channel with the type word and both case mappings.
// The csr_ channel sets the three range counts; csr_ready is always high.
// A negative code goes straight to the result with type 0 and its own code as
// both case mappings, a direct code reads the direct tables, and a range code
// searches the three range tables side by side; a type store read may follow a
// type hit whose entry uses types. Each table's search takes at most
// 1+log2(MAX_RANGES) compare steps.
// Each step is a range memory read followed by the compare.
// One query is worked at a time; req_stall is high until the result is handed to
// the output register, and write items leave the sequencer idle.
// Reset clears the sequencer, the output valid and the counts; table contents
// are not cleared and must be written before use. When the receiver stalls the
// result holds in the output register and the next result waits in the sequencer.
module rune_type_and_case_lookup #(
   parameter int DIRECT_SIZE = rtcl_pkg::DIRECT_SIZE_DEF,
   parameter int MAX_RANGES  = rtcl_pkg::MAX_RANGES_DEF,
   parameter int TYPE_WORDS  = rtcl_pkg::TYPE_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [1:0]                          req_table_select,
   input  logic [rtcl_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [31:0]                  req_char_code,
   input  logic [31:0]                         req_range_low,
   input  logic [31:0]                         req_range_high,
   input  logic signed [31:0]                  req_range_value,
   input  logic                                req_range_uses_types,
   input  logic [rtcl_pkg::INDEX_W-1:0]        req_types_base,
   input  logic [31:0]                         req_table_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_char_type,
   output logic signed [31:0]                  rsp_lower_code,
   output logic signed [31:0]                  rsp_upper_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [rtcl_pkg::COUNT_W-1:0]        csr_data
);

   localparam int DW  = $clog2(DIRECT_SIZE);
   localparam int TWW = (TYPE_WORDS > 1) ? $clog2(TYPE_WORDS) : 1;

   rtcl_pkg::state_type state_ff, state_in;

   logic [rtcl_pkg::COUNT_W-1:0] type_count_ff, lower_count_ff, upper_count_ff;
   logic [31:0] code_ff, code_in;
   logic [31:0] res_type_ff, res_type_in;
   logic [31:0] res_lower_ff, res_lower_in;
   logic [31:0] res_upper_ff, res_upper_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_type_ff, out_lower_ff, out_upper_ff;

   logic [31:0] direct_type_mem  [DIRECT_SIZE];
   logic [31:0] direct_lower_mem [DIRECT_SIZE];
   logic [31:0] direct_upper_mem [DIRECT_SIZE];
   logic [31:0] type_word_mem    [TYPE_WORDS];
   logic [31:0] dtype_rd_ff, dlower_rd_ff, dupper_rd_ff, word_rd_ff;

   logic        req_accept, direct_rd, word_rd, search_start, out_load;
   logic [31:0] word_addr;
   logic        wr_direct, wr_range, wr_word;
   rtcl_pkg::range_entry_type wr_entry;
   rtcl_pkg::search_status_type ts_status, ls_status, us_status;
   rtcl_pkg::range_entry_type   ts_entry, ls_entry, us_entry;

   assign req_stall  = (state_ff != rtcl_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Write decode, with out-of-range writes dropped.
   assign wr_direct = req_accept && req_kind == rtcl_pkg::KIND_DIRECT
                      && 32'(req_entry_index) < 32'(DIRECT_SIZE);
   assign wr_range  = req_accept && req_kind == rtcl_pkg::KIND_RANGE
                      && 32'(req_entry_index) < 32'(MAX_RANGES);
   assign wr_word   = req_accept && req_kind == rtcl_pkg::KIND_WORD
                      && 32'(req_entry_index) < 32'(TYPE_WORDS);

   always_comb begin
      wr_entry.low        = req_range_low;
      wr_entry.high       = req_range_high;
      wr_entry.value      = req_range_value;
      wr_entry.uses_types = (req_table_select == rtcl_pkg::SEL_TYPE) && req_range_uses_types;
      wr_entry.base       = (req_table_select == rtcl_pkg::SEL_TYPE) ? req_types_base : '0;
   end

   // Query decode: direct read for small codes, search for the other non-negative codes.
   assign direct_rd    = req_accept && req_kind == rtcl_pkg::KIND_QUERY
                         && !req_char_code[31] && 32'(req_char_code) < 32'(DIRECT_SIZE);
   assign search_start = req_accept && req_kind == rtcl_pkg::KIND_QUERY
                         && !req_char_code[31] && 32'(req_char_code) >= 32'(DIRECT_SIZE);

   // Direct tables.
   always_ff @(posedge clock) begin
      if (wr_direct && req_table_select == rtcl_pkg::SEL_TYPE) begin
         direct_type_mem[DW'(req_entry_index)] <= req_table_word;
      end
      if (wr_direct && req_table_select == rtcl_pkg::SEL_LOWER) begin
         direct_lower_mem[DW'(req_entry_index)] <= req_table_word;
      end
      if (wr_direct && req_table_select == rtcl_pkg::SEL_UPPER) begin
         direct_upper_mem[DW'(req_entry_index)] <= req_table_word;
      end
      if (direct_rd) begin
         dtype_rd_ff  <= direct_type_mem[DW'(req_char_code)];
         dlower_rd_ff <= direct_lower_mem[DW'(req_char_code)];
         dupper_rd_ff <= direct_upper_mem[DW'(req_char_code)];
      end
   end

   // Type word store.
   assign word_addr = 32'(ts_entry.base) + (code_ff - ts_entry.low);
   assign word_rd   = state_ff == rtcl_pkg::ST_SEARCH && ts_status.done && ls_status.done
                      && us_status.done && ts_status.hit && ts_entry.uses_types
                      && word_addr < 32'(TYPE_WORDS);

   always_ff @(posedge clock) begin
      if (wr_word) begin
         type_word_mem[TWW'(req_entry_index)] <= req_table_word;
      end
      if (word_rd) begin
         word_rd_ff <= type_word_mem[TWW'(word_addr)];
      end
   end

   // The three range tables search side by side on the registered code.
   rtcl_range_search #(.MAX_RANGES(MAX_RANGES)) u_type_search (
      .clock(clock), .reset(reset),
      .wr_en(wr_range && req_table_select == rtcl_pkg::SEL_TYPE),
      .wr_slot(req_entry_index), .wr_entry(wr_entry),
      .start(search_start), .count(type_count_ff), .code(code_ff),
      .status(ts_status), .entry(ts_entry)
   );

   rtcl_range_search #(.MAX_RANGES(MAX_RANGES)) u_lower_search (
      .clock(clock), .reset(reset),
      .wr_en(wr_range && req_table_select == rtcl_pkg::SEL_LOWER),
      .wr_slot(req_entry_index), .wr_entry(wr_entry),
      .start(search_start), .count(lower_count_ff), .code(code_ff),
      .status(ls_status), .entry(ls_entry)
   );

   rtcl_range_search #(.MAX_RANGES(MAX_RANGES)) u_upper_search (
      .clock(clock), .reset(reset),
      .wr_en(wr_range && req_table_select == rtcl_pkg::SEL_UPPER),
      .wr_slot(req_entry_index), .wr_entry(wr_entry),
      .start(search_start), .count(upper_count_ff), .code(code_ff),
      .status(us_status), .entry(us_entry)
   );

   // Sequencer: next state and result assembly.
   assign out_load = state_ff == rtcl_pkg::ST_RESULT && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      res_type_in  = res_type_ff;
      res_lower_in = res_lower_ff;
      res_upper_in = res_upper_ff;
      case (state_ff)
         rtcl_pkg::ST_IDLE: begin
            if (req_accept && req_kind == rtcl_pkg::KIND_QUERY) begin
               code_in = 32'(req_char_code);
               if (req_char_code[31]) begin
                  res_type_in  = '0;
                  res_lower_in = 32'(req_char_code);
                  res_upper_in = 32'(req_char_code);
                  state_in     = rtcl_pkg::ST_RESULT;
               end else if (direct_rd) begin
                  state_in = rtcl_pkg::ST_DIRECT;
               end else begin
                  state_in = rtcl_pkg::ST_SEARCH;
               end
            end
         end
         rtcl_pkg::ST_DIRECT: begin
            res_type_in  = dtype_rd_ff;
            res_lower_in = dlower_rd_ff;
            res_upper_in = dupper_rd_ff;
            state_in     = rtcl_pkg::ST_RESULT;
         end
         rtcl_pkg::ST_SEARCH: begin
            if (ts_status.done && ls_status.done && us_status.done) begin
               res_lower_in = ls_status.hit ? ls_entry.value + code_ff - ls_entry.low : code_ff;
               res_upper_in = us_status.hit ? us_entry.value + code_ff - us_entry.low : code_ff;
               res_type_in  = (ts_status.hit && !ts_entry.uses_types) ? ts_entry.value : '0;
               state_in     = word_rd ? rtcl_pkg::ST_WORD : rtcl_pkg::ST_RESULT;
            end
         end
         rtcl_pkg::ST_WORD: begin
            res_type_in = word_rd_ff;
            state_in    = rtcl_pkg::ST_RESULT;
         end
         rtcl_pkg::ST_RESULT: begin
            if (out_load) begin
               state_in = rtcl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtcl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff      <= code_in;
      res_type_ff  <= res_type_in;
      res_lower_ff <= res_lower_in;
      res_upper_ff <= res_upper_in;
   end

   // Output register; a transfer frees it for the next result.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         out_type_ff  <= res_type_ff;
         out_lower_ff <= res_lower_ff;
         out_upper_ff <= res_upper_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_type  = out_type_ff;
   assign rsp_lower_code = out_lower_ff;
   assign rsp_upper_code = out_upper_ff;

   // Range count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         type_count_ff  <= '0;
         lower_count_ff <= '0;
         upper_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rtcl_pkg::REG_TYPE_COUNT:  type_count_ff  <= csr_data;
            rtcl_pkg::REG_LOWER_COUNT: lower_count_ff <= csr_data;
            rtcl_pkg::REG_UPPER_COUNT: upper_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // A type store read only follows a finished search.
   a_word_after_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtcl_pkg::ST_WORD |-> $past(state_ff) == rtcl_pkg::ST_SEARCH)
      else $error("type store read without a search");

   // The output register fills only from the result state.
   a_load_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rtcl_pkg::ST_RESULT)
      else $error("result loaded outside the result state");

   // Starting a search always moves the sequencer into the search state.
   a_start_to_search: assert property (@(posedge clock) disable iff (reset)
      search_start |=> state_ff == rtcl_pkg::ST_SEARCH)
      else $error("search started without the sequencer following");

endmodule
